/* rtl/udn_pkg.sv */
// Package for the URI decoder and normaliser: sizes, status codes,
// character constants and the fragment table entry type. No dependencies.
`default_nettype none
package udn_pkg;
	localparam int BufDepth = 1024;
	localparam int AddrW    = $clog2(BufDepth);
	localparam int MaxFrag  = 32;
	localparam int FragW    = $clog2(MaxFrag);

	typedef enum logic [1:0] {
		OP_BYTE     = 2'd0,
		OP_END      = 2'd1,
		OP_RD_BYTE  = 2'd2,
		OP_RD_FRAG  = 2'd3
	} op_t;

	localparam logic [2:0] ST_STORED    = 3'd0;
	localparam logic [2:0] ST_SWALLOWED = 3'd1;
	localparam logic [2:0] ST_FORBIDDEN = 3'd2;
	localparam logic [2:0] ST_TOO_MANY  = 3'd3;
	localparam logic [2:0] ST_NO_SPACE  = 3'd4;
	localparam logic [2:0] ST_TRUNC     = 3'd5;
	localparam logic [2:0] ST_READ      = 3'd6;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_QUERY = 8'h3F;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef struct packed {
		logic [AddrW-1:0] off;
		logic [AddrW:0]   len;
		logic             cut;
	} frag_t;
endpackage
`default_nettype wire

/* rtl/uri_decode_normalize.sv */
// URI percent decoder and path normaliser, top level.
// Depends on udn_pkg. Holds the byte store and fragment table memories.
// A word is accepted only in the idle state, and the next only after the result of the last
// is loaded into the output registers, which waits while an earlier result is still unread.
// On "/../" the path is walked back byte by byte to the previous slash before the result.
// Reset returns the control state to its start; the memories and the result registers are not cleared.
`default_nettype none
module uri_decode_normalize (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [10:0]               cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                opcode,
	input  wire logic [7:0]                char_in,
	input  wire logic [udn_pkg::AddrW-1:0] read_index,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [2:0]                     status,
	output logic [7:0]                     byte_out,
	output logic [udn_pkg::AddrW-1:0]      fragment_offset,
	output logic [udn_pkg::AddrW:0]        fragment_length,
	output logic [udn_pkg::FragW:0]        fragment_total,
	output logic                           args_seen,
	output logic [udn_pkg::AddrW:0]        fill_position
);
	import udn_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PATH, S_DOT2, S_TAIL, S_OPEN, S_BK_START, S_BK_CHK, S_BK_END,
		S_END_SLASH, S_END_BK, S_END_NUL, S_RD_BYTE, S_RD_FRAG, S_DONE
	} state_t;

	localparam logic [AddrW:0] DepthV = (AddrW+1)'(BufDepth);

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
		if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h57)};
		if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h37)};
		return 5'h10;
	endfunction

	state_t           state_q;
	logic [10:0]      tll_q, dsl_q;
	logic [1:0]       esc_q, pp_q;
	logic [7:0]       stash_q;
	logic             ale_q, args_q;
	logic [AddrW:0]   fill_q;
	logic [FragW-1:0] cnt_q;
	logic [AddrW-1:0] cur_off_q;
	logic [AddrW:0]   cur_len_q;
	logic             cur_cut_q;
	logic [7:0]       c_q;
	logic             enc_q, query_q, bk_end_q, use_rd_q;
	logic [2:0]       st_q;
	logic [7:0]       bout_q;
	logic [AddrW-1:0] rd_off_q;
	logic [AddrW:0]   rd_len_q;
	logic             out_valid_q;
	logic [2:0]       status_q;
	logic [7:0]       byte_out_q;
	logic [AddrW-1:0] off_out_q;
	logic [AddrW:0]   len_out_q;
	logic [FragW:0]   total_out_q;
	logic             args_out_q;
	logic [AddrW:0]   fill_out_q;

	logic [7:0]       store_mem [BufDepth];
	logic [7:0]       store_rdata;
	frag_t            tbl_mem [MaxFrag];
	frag_t            tbl_rdata;

	logic             e_do, e_cnt, e_space, e_keep, e_wr;
	logic [7:0]       e_c;
	logic [AddrW:0]   lim;
	logic             s_re;
	logic [AddrW-1:0] s_raddr;
	logic             t_re, t_we, open_ok;
	logic [4:0]       hv_c, hv_s;
	logic             is_sep;

	assign lim     = (dsl_q < DepthV) ? dsl_q : DepthV;
	assign e_space = fill_q < lim;
	assign e_keep  = cur_len_q < tll_q;
	assign e_wr    = e_do && e_space && !cur_cut_q;
	assign open_ok = cnt_q != FragW'(MaxFrag - 1);
	assign hv_c    = hex_val(char_in);
	assign hv_s    = hex_val(stash_q);
	assign is_sep  = (c_q == CH_AMP || c_q == CH_SEMI) && !enc_q;

	always_comb begin
		e_do  = 1'b0;
		e_c   = CH_NUL;
		e_cnt = 1'b1;
		unique case (state_q)
			S_PATH: begin
				if (pp_q == 2'd0 && c_q != CH_NUL && is_sep) begin
					e_do  = 1'b1;
					e_c   = c_q;
					e_cnt = 1'b0;
				end else if (pp_q == 2'd2 && c_q != CH_DOT && c_q != CH_SLASH) begin
					e_do = 1'b1;
					e_c  = CH_DOT;
				end else if (pp_q == 2'd3 && c_q != CH_SLASH && c_q != CH_QUERY) begin
					e_do = 1'b1;
					e_c  = CH_DOT;
				end
			end
			S_DOT2: begin
				e_do = 1'b1;
				e_c  = CH_DOT;
			end
			S_TAIL: begin
				e_do = !(c_q == CH_QUERY && !enc_q && !args_q && !query_q);
				e_c  = query_q ? CH_NUL : c_q;
			end
			S_END_SLASH: begin
				e_do = !args_q && cur_len_q == '0;
				e_c  = CH_SLASH;
			end
			S_END_NUL: begin
				e_do = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		s_re    = 1'b0;
		s_raddr = read_index;
		t_re    = 1'b0;
		t_we    = state_q == S_OPEN && open_ok;
		unique case (state_q)
			S_IDLE: begin
				s_re = in_valid && opcode == OP_RD_BYTE;
				t_re = in_valid && opcode == OP_RD_FRAG;
			end
			S_BK_START: begin
				s_re    = 1'b1;
				s_raddr = AddrW'(fill_q - 2'd2);
			end
			S_BK_CHK: begin
				s_re    = 1'b1;
				s_raddr = AddrW'(fill_q - 1'b1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (e_wr) store_mem[fill_q[AddrW-1:0]] <= e_keep ? e_c : CH_NUL;
		if (s_re) store_rdata <= store_mem[s_raddr];
	end

	always_ff @(posedge clk) begin
		if (t_we) tbl_mem[cnt_q] <= '{off: cur_off_q, len: cur_len_q, cut: cur_cut_q};
		if (t_re) tbl_rdata <= tbl_mem[read_index[FragW-1:0]];
	end

	assign in_ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tll_q       <= 11'd1024;
			dsl_q       <= 11'd1024;
			esc_q       <= '0;
			pp_q        <= '0;
			stash_q     <= '0;
			ale_q       <= 1'b0;
			args_q      <= 1'b0;
			fill_q      <= '0;
			cnt_q       <= '0;
			cur_off_q   <= '0;
			cur_len_q   <= '0;
			cur_cut_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index) dsl_q <= cfg_data;
				else tll_q <= cfg_data;
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (e_wr) begin
				fill_q <= fill_q + 1'b1;
				if (e_keep) begin
					if (e_c != CH_NUL && e_cnt) cur_len_q <= cur_len_q + 1'b1;
				end else begin
					cur_cut_q <= 1'b1;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					bout_q   <= CH_NUL;
					use_rd_q <= 1'b0;
					bk_end_q <= 1'b0;
					query_q  <= 1'b0;
					if (in_valid) begin
						unique case (op_t'(opcode))
							OP_RD_BYTE: state_q <= S_RD_BYTE;
							OP_RD_FRAG: begin
								st_q     <= ST_READ;
								use_rd_q <= 1'b1;
								if (read_index >= AddrW'(MaxFrag)) begin
									rd_off_q <= '0;
									rd_len_q <= '0;
									state_q  <= S_DONE;
								end else if (read_index[FragW-1:0] == cnt_q) begin
									rd_off_q <= cur_off_q;
									rd_len_q <= cur_len_q;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_RD_FRAG;
								end
							end
							OP_END: begin
								if (esc_q != 2'd0) begin
									st_q    <= ST_FORBIDDEN;
									state_q <= S_DONE;
								end else begin
									state_q <= S_END_SLASH;
								end
							end
							OP_BYTE: begin
								c_q   <= char_in;
								enc_q <= 1'b0;
								priority case (esc_q)
									2'd0: begin
										if (char_in == CH_PCT) begin
											esc_q   <= 2'd1;
											st_q    <= ST_SWALLOWED;
											state_q <= S_DONE;
										end else begin
											state_q <= S_PATH;
										end
									end
									2'd1: begin
										state_q <= S_DONE;
										if (hv_c[4]) begin
											esc_q <= 2'd0;
											st_q  <= ST_FORBIDDEN;
										end else begin
											stash_q <= char_in;
											esc_q   <= 2'd2;
											st_q    <= ST_SWALLOWED;
										end
									end
									default: begin
										esc_q <= 2'd0;
										if (hv_c[4]) begin
											st_q    <= ST_FORBIDDEN;
											state_q <= S_DONE;
										end else begin
											c_q     <= {hv_s[3:0], hv_c[3:0]};
											enc_q   <= 1'b1;
											state_q <= S_PATH;
										end
									end
								endcase
							end
						endcase
					end
				end
				S_PATH: begin
					unique case (pp_q)
						2'd0: begin
							if (c_q == CH_NUL) begin
								st_q    <= ST_NO_SPACE;
								state_q <= S_DONE;
							end else if (is_sep) begin
								if (!e_space) begin
									st_q    <= ST_NO_SPACE;
									state_q <= S_DONE;
								end else begin
									state_q <= S_OPEN;
								end
							end else begin
								if (c_q == CH_EQUAL && enc_q && args_q && !ale_q) c_q <= CH_UNDER;
								if (c_q == CH_EQUAL && !enc_q) ale_q <= 1'b1;
								if (c_q == CH_PLUS && !enc_q) c_q <= CH_SPACE;
								if (c_q == CH_SLASH && !args_q) pp_q <= 2'd1;
								state_q <= S_TAIL;
							end
						end
						2'd1: begin
							if (c_q == CH_SLASH) begin
								st_q    <= ST_SWALLOWED;
								state_q <= S_DONE;
							end else if (c_q == CH_DOT) begin
								pp_q    <= 2'd2;
								st_q    <= ST_SWALLOWED;
								state_q <= S_DONE;
							end else begin
								pp_q    <= 2'd0;
								state_q <= S_TAIL;
							end
						end
						2'd2: begin
							if (c_q == CH_DOT) begin
								pp_q    <= 2'd3;
								st_q    <= ST_SWALLOWED;
								state_q <= S_DONE;
							end else if (c_q == CH_SLASH) begin
								pp_q    <= 2'd1;
								st_q    <= ST_SWALLOWED;
								state_q <= S_DONE;
							end else begin
								pp_q <= 2'd0;
								if (!e_space) begin
									st_q    <= ST_NO_SPACE;
									state_q <= S_DONE;
								end else begin
									state_q <= S_TAIL;
								end
							end
						end
						default: begin
							if (c_q == CH_SLASH || c_q == CH_QUERY) begin
								state_q <= S_BK_START;
							end else if (!e_space) begin
								st_q    <= ST_NO_SPACE;
								state_q <= S_DONE;
							end else begin
								state_q <= S_DOT2;
							end
						end
					endcase
				end
				S_DOT2: begin
					if (!e_space) begin
						st_q    <= ST_NO_SPACE;
						state_q <= S_DONE;
					end else begin
						pp_q    <= 2'd0;
						state_q <= S_TAIL;
					end
				end
				S_BK_START: begin
					if (cur_len_q > 2 && fill_q >= 2) begin
						fill_q    <= fill_q - 2'd2;
						cur_len_q <= cur_len_q - 2'd2;
						state_q   <= S_BK_CHK;
					end else begin
						state_q <= S_BK_END;
					end
				end
				S_BK_CHK: begin
					if (cur_len_q > 1 && fill_q != '0 && store_rdata != CH_SLASH) begin
						fill_q    <= fill_q - 1'b1;
						cur_len_q <= cur_len_q - 1'b1;
					end else begin
						state_q <= S_BK_END;
					end
				end
				S_BK_END: begin
					if (bk_end_q) begin
						state_q <= S_END_NUL;
					end else begin
						pp_q <= 2'd1;
						if (!(c_q == CH_QUERY && !enc_q) && cur_len_q <= 1) begin
							st_q    <= ST_SWALLOWED;
							state_q <= S_DONE;
						end else begin
							state_q <= S_TAIL;
						end
					end
				end
				S_TAIL: begin
					if (c_q == CH_QUERY && !enc_q && !args_q && !query_q) begin
						query_q <= 1'b1;
					end else if (query_q) begin
						if (!e_space) begin
							st_q    <= ST_NO_SPACE;
							state_q <= S_DONE;
						end else begin
							state_q <= S_OPEN;
						end
					end else begin
						state_q <= S_DONE;
						if (!e_space) st_q <= ST_NO_SPACE;
						else if (cur_cut_q || !e_keep) st_q <= ST_TRUNC;
						else begin
							st_q   <= ST_STORED;
							bout_q <= c_q;
						end
					end
				end
				S_OPEN: begin
					state_q <= S_DONE;
					if (!open_ok) begin
						st_q <= ST_TOO_MANY;
					end else begin
						cnt_q     <= cnt_q + 1'b1;
						cur_off_q <= fill_q[AddrW-1:0];
						cur_len_q <= '0;
						cur_cut_q <= 1'b0;
						ale_q     <= 1'b0;
						st_q      <= ST_SWALLOWED;
						if (query_q) begin
							args_q <= 1'b1;
							pp_q   <= 2'd0;
						end
					end
				end
				S_END_SLASH: begin
					if (e_do && !e_space) begin
						st_q    <= ST_NO_SPACE;
						state_q <= S_DONE;
					end else begin
						state_q <= S_END_BK;
					end
				end
				S_END_BK: begin
					bk_end_q <= 1'b1;
					state_q  <= (pp_q == 2'd3) ? S_BK_START : S_END_NUL;
				end
				S_END_NUL: begin
					pp_q    <= 2'd0;
					st_q    <= e_space ? ST_STORED : ST_NO_SPACE;
					state_q <= S_DONE;
				end
				S_RD_BYTE: begin
					st_q    <= ST_READ;
					bout_q  <= store_rdata;
					state_q <= S_DONE;
				end
				S_RD_FRAG: begin
					rd_off_q <= tbl_rdata.off;
					rd_len_q <= tbl_rdata.len;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= st_q;
						byte_out_q  <= bout_q;
						off_out_q   <= use_rd_q ? rd_off_q : cur_off_q;
						len_out_q   <= use_rd_q ? rd_len_q : cur_len_q;
						total_out_q <= {1'b0, cnt_q} + 1'b1;
						args_out_q  <= args_q;
						fill_out_q  <= fill_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign byte_out        = byte_out_q;
	assign fragment_offset = off_out_q;
	assign fragment_length = len_out_q;
	assign fragment_total  = total_out_q;
	assign args_seen       = args_out_q;
	assign fill_position   = fill_out_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DepthV) else $error("fill pointer beyond buffer depth");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		e_wr |-> fill_q < lim) else $error("store written beyond space limit");
	a_args_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(args_q) |-> args_q) else $error("argument flag cleared");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q != S_IDLE) else $error("word lost at accept");
`endif
endmodule
`default_nettype wire

/* tb/tb_uri_decode_normalize_chk.sv */
// Checker for the URI decoder: watches both word channels and the register port,
// predicts every result word from its own copy of the block state and compares.
// Depends on udn_pkg.
`timescale 1ns / 1ps
module tb_uri_decode_normalize_chk
	import udn_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [10:0]        cfg_data,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [1:0]         opcode,
	input  wire logic [7:0]         char_in,
	input  wire logic [AddrW-1:0]   read_index,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic [2:0]         status,
	input  wire logic [7:0]         byte_out,
	input  wire logic [AddrW-1:0]   fragment_offset,
	input  wire logic [AddrW:0]     fragment_length,
	input  wire logic [FragW:0]     fragment_total,
	input  wire logic               args_seen,
	input  wire logic [AddrW:0]     fill_position,
	output int                      fail_count,
	output int                      replies_due,
	output int                      bytes_written,
	output int                      frags_opened
);
	typedef struct packed {
		logic [2:0]       st;
		logic [7:0]       bval;
		logic [AddrW-1:0] off;
		logic [AddrW:0]   len;
		logic [FragW:0]   total;
		logic             args;
		logic [AddrW:0]   fill;
	} reply_t;

	reply_t reply_q[$];
	int errs = 0;

	logic [10:0] tok_limit = 11'd1024;
	logic [10:0] space_cfg = 11'd1024;
	int          esc_phase = 0;
	int          dir_phase = 0;
	logic [7:0]  hex_hold  = 8'd0;
	bit          saw_equal = 0;
	bit          in_args   = 0;
	int          fill_ptr  = 0;
	int          frag_cur  = 0;
	int          fill_max  = 0;
	int          frag_max  = 0;
	logic [7:0]  store [BufDepth];
	int          frag_off [MaxFrag];
	int          frag_size [MaxFrag];
	bit          frag_cut [MaxFrag];

	assign fail_count = errs;

	initial begin
		for (int i = 0; i < BufDepth; i++)
			store[i] = 8'd0;
		for (int i = 0; i < MaxFrag; i++) begin
			frag_off[i] = 0;
			frag_size[i] = 0;
			frag_cut[i] = 0;
		end
	end

	function automatic int nibble(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return 16;
	endfunction

	// -1 no room, 0 stored, 1 cut off
	function automatic int put_byte(logic [7:0] c, bit counted);
		int lim;
		lim = (space_cfg < BufDepth) ? int'(space_cfg) : BufDepth;
		if (fill_ptr >= lim) return -1;
		if (frag_cut[frag_cur]) return 1;
		if (frag_size[frag_cur] < tok_limit) begin
			store[fill_ptr] = c;
			fill_ptr++;
			if (c != CH_NUL && counted) frag_size[frag_cur]++;
		end else begin
			store[fill_ptr] = CH_NUL;
			fill_ptr++;
			frag_cut[frag_cur] = 1;
		end
		if (fill_ptr > fill_max) fill_max = fill_ptr;
		return frag_cut[frag_cur] ? 1 : 0;
	endfunction

	function automatic bit next_frag();
		if (frag_cur + 1 >= MaxFrag) return 0;
		frag_cur++;
		frag_off[frag_cur] = fill_ptr;
		frag_size[frag_cur] = 0;
		frag_cut[frag_cur] = 0;
		if (frag_cur > frag_max) frag_max = frag_cur;
		return 1;
	endfunction

	function automatic void walk_back();
		if (frag_size[frag_cur] > 2 && fill_ptr >= 2) begin
			fill_ptr--;
			frag_size[frag_cur]--;
			do begin
				fill_ptr--;
				frag_size[frag_cur]--;
			end while (frag_size[frag_cur] > 1 && fill_ptr > 0 && store[fill_ptr] != CH_SLASH);
		end
	endfunction

	function automatic logic [2:0] decode_char(logic [7:0] raw, output logic [7:0] bval);
		logic [7:0] c;
		bit enc;
		int r;
		c = raw;
		enc = 0;
		bval = 8'd0;
		if (esc_phase == 0) begin
			if (c == CH_PCT) begin
				esc_phase = 1;
				return ST_SWALLOWED;
			end
		end else if (esc_phase == 1) begin
			esc_phase = 0;
			if (nibble(c) > 15) return ST_FORBIDDEN;
			hex_hold = c;
			esc_phase = 2;
			return ST_SWALLOWED;
		end else begin
			esc_phase = 0;
			if (nibble(c) > 15) return ST_FORBIDDEN;
			c = 8'((nibble(hex_hold) << 4) | nibble(c));
			enc = 1;
		end

		case (dir_phase)
			0: begin
				if (c == CH_NUL) return ST_NO_SPACE;
				if ((c == CH_AMP || c == CH_SEMI) && !enc) begin
					if (put_byte(c, 0) < 0) return ST_NO_SPACE;
					if (!next_frag()) return ST_TOO_MANY;
					saw_equal = 0;
					return ST_SWALLOWED;
				end
				if (c == CH_EQUAL && enc && in_args && !saw_equal) c = CH_UNDER;
				if (c == CH_EQUAL && !enc) saw_equal = 1;
				if (c == CH_PLUS && !enc) c = CH_SPACE;
				if (c == CH_SLASH && !in_args) dir_phase = 1;
			end
			1: begin
				if (c == CH_SLASH) return ST_SWALLOWED;
				if (c == CH_DOT) begin
					dir_phase = 2;
					return ST_SWALLOWED;
				end
				dir_phase = 0;
			end
			2: begin
				if (c == CH_DOT) begin
					dir_phase = 3;
					return ST_SWALLOWED;
				end
				if (c == CH_SLASH) begin
					dir_phase = 1;
					return ST_SWALLOWED;
				end
				dir_phase = 0;
				if (put_byte(CH_DOT, 1) < 0) return ST_NO_SPACE;
			end
			default: begin
				if (c == CH_SLASH || c == CH_QUERY) begin
					walk_back();
					dir_phase = 1;
					if (!(c == CH_QUERY && !enc) && frag_size[frag_cur] <= 1)
						return ST_SWALLOWED;
				end else begin
					if (put_byte(CH_DOT, 1) < 0) return ST_NO_SPACE;
					if (put_byte(CH_DOT, 1) < 0) return ST_NO_SPACE;
					dir_phase = 0;
				end
			end
		endcase

		if (c == CH_QUERY && !enc && !in_args) begin
			if (put_byte(CH_NUL, 1) < 0) return ST_NO_SPACE;
			if (!next_frag()) return ST_TOO_MANY;
			saw_equal = 0;
			in_args = 1;
			dir_phase = 0;
			return ST_SWALLOWED;
		end
		r = put_byte(c, 1);
		if (r < 0) return ST_NO_SPACE;
		if (r > 0) return ST_TRUNC;
		bval = c;
		return ST_STORED;
	endfunction

	function automatic logic [2:0] close_uri();
		if (esc_phase != 0) return ST_FORBIDDEN;
		if (!in_args && frag_size[frag_cur] == 0)
			if (put_byte(CH_SLASH, 1) < 0) return ST_NO_SPACE;
		if (dir_phase == 3) walk_back();
		dir_phase = 0;
		if (put_byte(CH_NUL, 1) < 0) return ST_NO_SPACE;
		return ST_STORED;
	endfunction

	function automatic reply_t normalize_word(op_t op, logic [7:0] c, logic [AddrW-1:0] idx);
		reply_t r;
		logic [7:0] b;
		int o;
		int l;
		b = 8'd0;
		case (op)
			OP_BYTE: r.st = decode_char(c, b);
			OP_END:  r.st = close_uri();
			OP_RD_BYTE: begin
				r.st = ST_READ;
				b = store[idx];
			end
			default: r.st = ST_READ;
		endcase
		o = frag_off[frag_cur];
		l = frag_size[frag_cur];
		if (op == OP_RD_FRAG) begin
			o = (idx < MaxFrag) ? frag_off[idx] : 0;
			l = (idx < MaxFrag) ? frag_size[idx] : 0;
		end
		r.bval  = b;
		r.off   = o[AddrW-1:0];
		r.len   = l[AddrW:0];
		r.total = 6'(frag_cur + 1);
		r.args  = in_args;
		r.fill  = fill_ptr[AddrW:0];
		return r;
	endfunction

	task automatic report(string field, int want, int got);
		$display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
		errs++;
	endtask

	always @(posedge clk) begin
		reply_t w;
		if (cfg_we) begin
			if (cfg_index) space_cfg = cfg_data;
			else tok_limit = cfg_data;
		end
		if (out_valid && out_ready) begin
			if (reply_q.size() == 0) begin
				report("unexpected word", 0, 1);
			end else begin
				w = reply_q.pop_front();
				if (status != w.st) report("status", w.st, status);
				if (byte_out != w.bval) report("byte_out", w.bval, byte_out);
				if (fragment_offset != w.off) report("fragment_offset", w.off, fragment_offset);
				if (fragment_length != w.len) report("fragment_length", w.len, fragment_length);
				if (fragment_total != w.total) report("fragment_total", w.total, fragment_total);
				if (args_seen != w.args) report("args_seen", w.args, args_seen);
				if (fill_position != w.fill) report("fill_position", w.fill, fill_position);
			end
		end
		if (in_valid && in_ready)
			reply_q.push_back(normalize_word(op_t'(opcode), char_in, read_index));
		replies_due <= reply_q.size();
		bytes_written <= fill_max;
		frags_opened <= frag_max;
	end

	final_check: assert property (@(posedge clk) 1);
endmodule

/* tb/tb_uri_decode_normalize.sv */
// Top of the URI decoder testbench: clock, reset, register writes and word
// stimulus with random idling; the verdict comes from the checker's fail count.
// Depends on udn_pkg, uri_decode_normalize and tb_uri_decode_normalize_chk.
`timescale 1ns / 1ps
module tb_uri_decode_normalize;
	import udn_pkg::*;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic               cfg_index = 0;
	logic [10:0]        cfg_data = '0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [1:0]         opcode = OP_BYTE;
	logic [7:0]         char_in = '0;
	logic [AddrW-1:0]   read_index = '0;
	logic               out_valid;
	logic               out_ready = 0;
	logic [2:0]         status;
	logic [7:0]         byte_out;
	logic [AddrW-1:0]   fragment_offset;
	logic [AddrW:0]     fragment_length;
	logic [FragW:0]     fragment_total;
	logic               args_seen;
	logic [AddrW:0]     fill_position;
	int                 fail_count;
	int                 replies_due;
	int                 bytes_written;
	int                 frags_opened;
	bit                 no_idle = 0;
	logic [7:0]         esc_todo[$];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	uri_decode_normalize u_top (.*);

	tb_uri_decode_normalize_chk u_chk (.*);

	always @(posedge clk)
		out_ready <= no_idle || ($urandom_range(99) >= 14);

	initial begin
		#5_000_000;
		$display("** uri_decode_normalize: FAILED **");
		$finish;
	end

	task automatic set_reg(bit idx, logic [10:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		in_valid <= 0;
		do @(posedge clk); while (replies_due != 0 || in_valid);
		repeat (20) @(posedge clk);
	endtask

	task automatic send(op_t op, logic [7:0] c, logic [AddrW-1:0] idx);
		if (!no_idle && $urandom_range(99) < 14) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		char_in <= c;
		read_index <= idx;
		forever begin
			@(negedge clk);
			if (in_ready) break;
		end
		@(posedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send(OP_BYTE, s[i], '0);
	endtask

	function automatic logic [7:0] hex_char();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(digits.len() - 1)];
	endfunction

	function automatic logic [7:0] uri_char();
		string common;
		int pick;
		common = "//..?&;+=%aZ9-";
		pick = $urandom_range(99);
		if (pick < 55) return common[$urandom_range(common.len() - 1)];
		if (pick < 85) return 8'($urandom_range("a", "z"));
		if (pick < 88) return CH_NUL;
		return 8'($urandom());
	endfunction

	task automatic random_word();
		int pick;
		logic [7:0] c;
		pick = $urandom_range(99);
		if (esc_todo.size() != 0) begin
			send(OP_BYTE, esc_todo.pop_front(), 10'($urandom()));
		end else if (pick < 72) begin
			c = uri_char();
			if (c == CH_PCT && $urandom_range(9) != 0) begin
				esc_todo.push_back($urandom_range(3) == 0 ? "3" : hex_char());
				esc_todo.push_back(hex_char());
			end
			send(OP_BYTE, c, 10'($urandom()));
		end else if (pick < 77) begin
			send(OP_END, 8'($urandom()), 10'($urandom()));
		end else if (pick < 88 && bytes_written > 0) begin
			send(OP_RD_BYTE, 8'($urandom()), 10'($urandom_range(bytes_written - 1)));
		end else if (frags_opened > 0 && $urandom_range(1) == 0) begin
			send(OP_RD_FRAG, 8'($urandom()), 10'($urandom_range(frags_opened)));
		end else begin
			send(OP_RD_FRAG, 8'($urandom()), 10'($urandom_range(MaxFrag, BufDepth - 1)));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		set_reg(0, 11'd1024);
		set_reg(1, 11'd1024);

		send_text("/a//./b/../%41%Z?%3D+&");
		send(OP_BYTE, CH_NUL, '0);
		send(OP_BYTE, CH_PCT, '0);
		send(OP_END, '0, '0);
		send_text("7e");
		send(OP_RD_BYTE, '0, '0);
		send(OP_RD_FRAG, '0, 10'd1);
		drain();

		set_reg(0, 11'd5);
		for (int i = 0; i < 900; i++)
			random_word();
		drain();

		set_reg(0, 11'd0);
		set_reg(1, 11'd1);
		for (int i = 0; i < 150; i++)
			random_word();
		drain();

		set_reg(0, 11'd1024);
		set_reg(1, 11'd1024);
		no_idle = 1;
		for (int i = 0; i < 950; i++) begin
			if (i == 300) no_idle = 0;
			random_word();
		end
		in_valid <= 0;
		drain();

		if (fail_count == 0)
			$display("** uri_decode_normalize: PASSED **");
		else
			$display("** uri_decode_normalize: FAILED **");
		$finish;
	end
endmodule
